// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, reset gated.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds while the reset is released.
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/chrcov_pkg.sv -----
// ---------------------------------------------------------------------------
// chrcov_pkg
// Shared widths, constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package chrcov_pkg;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CHR_W   = 24;
  localparam int unsigned MOM_W   = 40;
  localparam int unsigned DVD_W   = 40;  // divider dividend / quotient
  localparam int unsigned DVS_W   = 32;  // divider divisor
  localparam int unsigned DCNT_W  = $clog2(DVD_W);

  localparam logic [7:0] THR_RESET = 8'd100;

  // division jobs, in issue order
  localparam logic [2:0] DIV_CHR_R = 3'd0;
  localparam logic [2:0] DIV_CHR_G = 3'd1;
  localparam logic [2:0] DIV_DLT_R = 3'd2;
  localparam logic [2:0] DIV_DLT_G = 3'd3;
  localparam logic [2:0] DIV_MOM_R = 3'd4;
  localparam logic [2:0] DIV_MOM_G = 3'd5;
  localparam logic [2:0] DIV_MOM_C = 3'd6;

  // moment selects
  localparam logic [1:0] MOM_R = 2'd0;
  localparam logic [1:0] MOM_G = 2'd1;
  localparam logic [1:0] MOM_C = 2'd2;

  // multiply phases
  localparam logic [1:0] PH_DXDY = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_UPD  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       div_start;
    logic       div_store;
    logic [2:0] div_sel;
    logic       mul_en;
    logic       upd;
    logic [1:0] mom_sel;
    logic [1:0] phase;
    logic       commit;
    logic       out_load;
    logic       out_acc;
    logic       out_full;
  } cmd_t;

  typedef struct packed {
    logic clr;
    logic qual;
    logic full;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/core/chromaticity_running_covariance_core.sv -----
// ---------------------------------------------------------------------------
// chromaticity_running_covariance_core
// Running r/g chromaticity mean and second moments of masked BGR pixels.
// ---------------------------------------------------------------------------
// Flow: a clear or rejected/dropped pixel passes from the decide state to
//   the result load; a sampled pixel first runs the divisions and moments.
// Throughput: one item at a time; a sampled pixel is set by seven passes
//   through the shared bit-serial divider (start, quotient bits, handoff)
//   plus the multiply/update phases. The next input transfer is taken while
//   a result still waits.
// Reset: asynchronous, active low; statistics zero, threshold 100.
// ---------------------------------------------------------------------------
module chromaticity_running_covariance_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [7:0]                           cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [7:0]                           pixel_blue_i,
  input  logic [7:0]                           pixel_green_i,
  input  logic [7:0]                           pixel_red_i,
  input  logic [7:0]                           mask_blue_i,
  input  logic [7:0]                           mask_green_i,
  input  logic [7:0]                           mask_red_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 accepted_o,
  output logic                                 count_full_o,
  output logic [chrcov_pkg::COUNT_W-1:0]       sample_count_o,
  output logic [chrcov_pkg::CHR_W-1:0]         mean_red_o,
  output logic [chrcov_pkg::CHR_W-1:0]         mean_green_o,
  output logic [chrcov_pkg::MOM_W-1:0]         moment_red_o,
  output logic [chrcov_pkg::MOM_W-1:0]         moment_green_o,
  output logic signed [chrcov_pkg::MOM_W-1:0]  moment_cross_o
);
  import chrcov_pkg::*;

  // Controller sequences the work; datapath holds all arithmetic and the statistics.
  cmd_t cmd;
  sts_t sts;

  chrcov_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The result register in the datapath is only reloaded once the previous
  // result transfer has happened, so a stalled consumer holds its payload.
  chrcov_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .pixel_blue_i   (pixel_blue_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_red_i    (pixel_red_i),
    .mask_blue_i    (mask_blue_i),
    .mask_green_i   (mask_green_i),
    .mask_red_i     (mask_red_i),
    .accepted_o     (accepted_o),
    .count_full_o   (count_full_o),
    .sample_count_o (sample_count_o),
    .mean_red_o     (mean_red_o),
    .mean_green_o   (mean_green_o),
    .moment_red_o   (moment_red_o),
    .moment_green_o (moment_green_o),
    .moment_cross_o (moment_cross_o)
  );

endmodule

// ----- rtl/core/chrcov_div.sv -----
// ---------------------------------------------------------------------------
// chrcov_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module chrcov_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [chrcov_pkg::DVD_W-1:0]  dividend_i,
  input  logic [chrcov_pkg::DVS_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [chrcov_pkg::DVD_W-1:0]  quotient_o
);
  import chrcov_pkg::*;

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W:0]    rem_sh, diff;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/chrcov_dp.sv -----
// ---------------------------------------------------------------------------
// chrcov_dp
// Datapath: statistics registers, shared divider, shared multiplier, result
// register.
// ---------------------------------------------------------------------------
module chrcov_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  chrcov_pkg::cmd_t               cmd_i,
  output chrcov_pkg::sts_t               sts_o,
  input  logic                           cfg_we_i,
  input  logic [7:0]                     cfg_wdata_i,
  input  logic                           func_i,
  input  logic [7:0]                     pixel_blue_i,
  input  logic [7:0]                     pixel_green_i,
  input  logic [7:0]                     pixel_red_i,
  input  logic [7:0]                     mask_blue_i,
  input  logic [7:0]                     mask_green_i,
  input  logic [7:0]                     mask_red_i,
  output logic                           accepted_o,
  output logic                           count_full_o,
  output logic [chrcov_pkg::COUNT_W-1:0] sample_count_o,
  output logic [chrcov_pkg::CHR_W-1:0]   mean_red_o,
  output logic [chrcov_pkg::CHR_W-1:0]   mean_green_o,
  output logic [chrcov_pkg::MOM_W-1:0]   moment_red_o,
  output logic [chrcov_pkg::MOM_W-1:0]   moment_green_o,
  output logic signed [chrcov_pkg::MOM_W-1:0] moment_cross_o
);
  import chrcov_pkg::*;

  localparam int unsigned PRD_W = 2 * CHR_W;         // dx*dy
  localparam int unsigned MUL_W = CHR_W + COUNT_W;   // shared multiplier
  localparam int unsigned ACC_W = PRD_W + 2;         // exact term*(n-1) fits
  localparam int unsigned TRM_W = ACC_W - 8;
  localparam int unsigned UPD_W = MOM_W + 4;

  localparam logic signed [UPD_W-1:0] VAR_MAX = UPD_W'({MOM_W{1'b1}});
  localparam logic signed [UPD_W-1:0] COV_MAX = UPD_W'({1'b0, {(MOM_W-1){1'b1}}});
  localparam logic signed [UPD_W-1:0] COV_MIN = -UPD_W'({1'b1, {(MOM_W-1){1'b0}}});

  // captured item
  logic       func_q;
  logic [7:0] pb_q, pg_q, pr_q, mb_q, mg_q, mr_q, thr_q;

  // statistics
  logic [COUNT_W-1:0]      count_q;
  logic [CHR_W-1:0]        mean_r_q, mean_g_q;
  logic [MOM_W-1:0]        mom_r_q, mom_g_q;
  logic signed [MOM_W-1:0] mom_c_q;

  // intermediates
  logic [CHR_W-1:0] r_q, g_q, dr_q, dg_q;
  logic             dr_neg_q, dg_neg_q;
  logic [MOM_W-1:0] qr_q, qg_q, qc_q;
  logic [PRD_W-1:0] p_q;
  logic [MUL_W-1:0] lo_q, hi_q;

  logic [9:0]       sum;
  logic signed [CHR_W:0] diff_r, diff_g;
  logic [CHR_W-1:0] mag_r, mag_g;
  logic [MOM_W-1:0] mag_c;
  logic [DVD_W-1:0] dvd, quo;
  logic [DVS_W-1:0] dvs;
  logic [CHR_W-1:0] quo_sat;
  logic             div_done;

  assign sum    = 10'(pr_q) + 10'(pg_q) + 10'(pb_q);
  assign diff_r = $signed({1'b0, r_q}) - $signed({1'b0, mean_r_q});
  assign diff_g = $signed({1'b0, g_q}) - $signed({1'b0, mean_g_q});
  assign mag_r  = diff_r[CHR_W] ? CHR_W'(-diff_r) : diff_r[CHR_W-1:0];
  assign mag_g  = diff_g[CHR_W] ? CHR_W'(-diff_g) : diff_g[CHR_W-1:0];
  assign mag_c  = mom_c_q[MOM_W-1] ? MOM_W'(-mom_c_q) : MOM_W'(mom_c_q);

  always_comb begin
    dvd = '0;
    dvs = DVS_W'(count_q) + 1'b1;
    case (cmd_i.div_sel)
      DIV_CHR_R: begin
        dvd = DVD_W'({pr_q, {CHR_W{1'b0}}});
        dvs = DVS_W'(sum);
      end
      DIV_CHR_G: begin
        dvd = DVD_W'({pg_q, {CHR_W{1'b0}}});
        dvs = DVS_W'(sum);
      end
      DIV_DLT_R: dvd = DVD_W'(mag_r);
      DIV_DLT_G: dvd = DVD_W'(mag_g);
      DIV_MOM_R: dvd = DVD_W'(mom_r_q);
      DIV_MOM_G: dvd = DVD_W'(mom_g_q);
      DIV_MOM_C: dvd = DVD_W'(mag_c);
      default:   dvd = '0;
    endcase
  end

  chrcov_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // r = 1.0 saturates to all ones
  assign quo_sat = (quo[DVD_W-1:CHR_W] != '0) ? {CHR_W{1'b1}} : quo[CHR_W-1:0];

  // shared multiplier
  logic [CHR_W-1:0]   mul_a, mdx, mdy;
  logic [COUNT_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_p;

  always_comb begin
    mdx = dr_q;
    mdy = dr_q;
    case (cmd_i.mom_sel)
      MOM_R:   begin mdx = dr_q; mdy = dr_q; end
      MOM_G:   begin mdx = dg_q; mdy = dg_q; end
      MOM_C:   begin mdx = dr_q; mdy = dg_q; end
      default: begin mdx = dr_q; mdy = dr_q; end
    endcase
    case (cmd_i.phase)
      PH_DXDY: begin mul_a = mdx;                  mul_b = COUNT_W'(mdy); end
      PH_LO:   begin mul_a = p_q[CHR_W-1:0];       mul_b = count_q;       end
      PH_HI:   begin mul_a = p_q[PRD_W-1:CHR_W];   mul_b = count_q;       end
      default: begin mul_a = '0;                   mul_b = '0;            end
    endcase
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // moment update: m + trunc0(dx*dy*(n-1)/256) - trunc0(m/n), clamped
  logic [ACC_W-1:0]        acc;
  logic [TRM_W-1:0]        trm_mag;
  logic                    trm_neg, m_neg;
  logic signed [UPD_W-1:0] m_old, trm_s, q_s, m_new, m_clip;
  logic [MOM_W-1:0]        q_mag;

  assign acc     = lo_q[ACC_W-1:0] + {hi_q[ACC_W-CHR_W-1:0], {CHR_W{1'b0}}};
  assign trm_mag = acc[ACC_W-1:8];

  always_comb begin
    trm_neg = 1'b0;
    m_neg   = 1'b0;
    m_old   = UPD_W'(mom_r_q);
    q_mag   = qr_q;
    case (cmd_i.mom_sel)
      MOM_R: begin m_old = UPD_W'(mom_r_q); q_mag = qr_q; end
      MOM_G: begin m_old = UPD_W'(mom_g_q); q_mag = qg_q; end
      MOM_C: begin
        m_old   = UPD_W'(mom_c_q);
        q_mag   = qc_q;
        m_neg   = mom_c_q[MOM_W-1];
        trm_neg = dr_neg_q ^ dg_neg_q;
      end
      default: begin m_old = UPD_W'(mom_r_q); q_mag = qr_q; end
    endcase
    trm_s = trm_neg ? -$signed(UPD_W'(trm_mag)) : $signed(UPD_W'(trm_mag));
    q_s   = m_neg ? -$signed(UPD_W'(q_mag)) : $signed(UPD_W'(q_mag));
    m_new = m_old + trm_s - q_s;
    if (cmd_i.mom_sel == MOM_C) begin
      m_clip = (m_new > COV_MAX) ? COV_MAX : ((m_new < COV_MIN) ? COV_MIN : m_new);
    end else begin
      m_clip = (m_new > VAR_MAX) ? VAR_MAX : ((m_new < 0) ? '0 : m_new);
    end
  end

  // mean update with clamp to [0, 1)
  logic signed [CHR_W+1:0] mr_new, mg_new;
  logic [CHR_W-1:0]        mr_clip, mg_clip;

  assign mr_new = dr_neg_q ? $signed({2'b0, mean_r_q}) - $signed({2'b0, dr_q})
                           : $signed({2'b0, mean_r_q}) + $signed({2'b0, dr_q});
  assign mg_new = dg_neg_q ? $signed({2'b0, mean_g_q}) - $signed({2'b0, dg_q})
                           : $signed({2'b0, mean_g_q}) + $signed({2'b0, dg_q});
  assign mr_clip = mr_new[CHR_W+1] ? '0 : (mr_new[CHR_W] ? {CHR_W{1'b1}} : mr_new[CHR_W-1:0]);
  assign mg_clip = mg_new[CHR_W+1] ? '0 : (mg_new[CHR_W] ? {CHR_W{1'b1}} : mg_new[CHR_W-1:0]);

  // status
  assign sts_o.clr      = func_q;
  assign sts_o.qual     = !func_q && (mb_q > thr_q) && (mg_q > thr_q) && (mr_q > thr_q)
                          && (sum != '0);
  assign sts_o.full     = (count_q == {COUNT_W{1'b1}});
  assign sts_o.div_done = div_done;

  // control-visible state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RESET;
      count_q  <= '0;
      mean_r_q <= '0;
      mean_g_q <= '0;
      mom_r_q  <= '0;
      mom_g_q  <= '0;
      mom_c_q  <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (cmd_i.clear) begin
        count_q  <= '0;
        mean_r_q <= '0;
        mean_g_q <= '0;
        mom_r_q  <= '0;
        mom_g_q  <= '0;
        mom_c_q  <= '0;
      end else begin
        if (cmd_i.upd) begin
          case (cmd_i.mom_sel)
            MOM_R:   mom_r_q <= m_clip[MOM_W-1:0];
            MOM_G:   mom_g_q <= m_clip[MOM_W-1:0];
            MOM_C:   mom_c_q <= m_clip[MOM_W-1:0];
            default: ;
          endcase
        end
        if (cmd_i.commit) begin
          count_q  <= count_q + 1'b1;
          mean_r_q <= mr_clip;
          mean_g_q <= mg_clip;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      pb_q   <= pixel_blue_i;
      pg_q   <= pixel_green_i;
      pr_q   <= pixel_red_i;
      mb_q   <= mask_blue_i;
      mg_q   <= mask_green_i;
      mr_q   <= mask_red_i;
    end
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        DIV_CHR_R: r_q <= quo_sat;
        DIV_CHR_G: g_q <= quo_sat;
        DIV_DLT_R: begin dr_q <= quo[CHR_W-1:0]; dr_neg_q <= diff_r[CHR_W]; end
        DIV_DLT_G: begin dg_q <= quo[CHR_W-1:0]; dg_neg_q <= diff_g[CHR_W]; end
        DIV_MOM_R: qr_q <= quo[MOM_W-1:0];
        DIV_MOM_G: qg_q <= quo[MOM_W-1:0];
        DIV_MOM_C: qc_q <= quo[MOM_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.phase)
        PH_DXDY: p_q  <= mul_p[PRD_W-1:0];
        PH_LO:   lo_q <= mul_p;
        PH_HI:   hi_q <= mul_p;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      accepted_o     <= cmd_i.out_acc;
      count_full_o   <= cmd_i.out_full;
      sample_count_o <= count_q;
      mean_red_o     <= mean_r_q;
      mean_green_o   <= mean_g_q;
      moment_red_o   <= mom_r_q;
      moment_green_o <= mom_g_q;
      moment_cross_o <= mom_c_q;
    end
  end

endmodule

// ----- rtl/core/chrcov_ctrl.sv -----
// ---------------------------------------------------------------------------
// chrcov_ctrl
// Sequencer: issues the seven divisions, the per-moment multiply passes,
// the commit and the result handoff.
// ---------------------------------------------------------------------------
module chrcov_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  chrcov_pkg::sts_t sts_i,
  output chrcov_pkg::cmd_t cmd_o
);
  import chrcov_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_DIVGO  = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] dsel_q, dsel_d;
  logic [1:0] msel_q, msel_d, ph_q, ph_d;
  logic       acc_q, acc_d, full_q, full_d, ov_q, ov_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    dsel_d  = dsel_q;
    msel_d  = msel_q;
    ph_d    = ph_q;
    acc_d   = acc_q;
    full_d  = full_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.div_sel  = dsel_q;
    cmd_o.mom_sel  = msel_q;
    cmd_o.phase    = ph_q;
    cmd_o.out_acc  = acc_q;
    cmd_o.out_full = full_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        acc_d  = 1'b0;
        full_d = 1'b0;
        dsel_d = DIV_CHR_R;
        if (sts_i.clr) begin
          cmd_o.clear = 1'b1;
          state_d     = S_OUT;
        end else if (!sts_i.qual) begin
          state_d = S_OUT;
        end else if (sts_i.full) begin
          full_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (dsel_q == DIV_MOM_C) begin
            msel_d  = MOM_R;
            ph_d    = PH_DXDY;
            state_d = S_MUL;
          end else begin
            dsel_d  = dsel_q + 1'b1;
            state_d = S_DIVGO;
          end
        end
      end
      S_MUL: begin
        if (ph_q == PH_UPD) begin
          cmd_o.upd = 1'b1;
          ph_d      = PH_DXDY;
          if (msel_q == MOM_C) begin
            state_d = S_COMMIT;
          end else begin
            msel_d = msel_q + 1'b1;
          end
        end else begin
          cmd_o.mul_en = 1'b1;
          ph_d         = ph_q + 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        acc_d        = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dsel_q  <= '0;
      msel_q  <= '0;
      ph_q    <= '0;
      acc_q   <= 1'b0;
      full_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      dsel_q  <= dsel_d;
      msel_q  <= msel_d;
      ph_q    <= ph_d;
      acc_q   <= acc_d;
      full_q  <= full_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ----- rtl/core/chrcov_chk.sv -----
// ---------------------------------------------------------------------------
// chrcov_chk
// Port-level checks for the chromaticity covariance core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chrcov_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        accepted_o,
  input logic        count_full_o,
  input logic [31:0] sample_count_o
);

  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `CHK_ASSERT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken while busy")
  `CHK_NEVER(a_flags_excl, clk_i, rst_ni, out_valid_o && accepted_o && count_full_o, "accepted and full together")
  `CHK_ASSERT(a_full_count, clk_i, rst_ni, out_valid_o && count_full_o |-> sample_count_o == 32'hFFFF_FFFF, "full flag with unsaturated count")
  `CHK_ASSERT(a_acc_count, clk_i, rst_ni, out_valid_o && accepted_o |-> sample_count_o != 32'd0, "accepted sample with zero count")

endmodule

bind chromaticity_running_covariance_core chrcov_chk u_chrcov_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .count_full_o   (count_full_o),
  .sample_count_o (sample_count_o)
);

// ----- tb/chromaticity_running_covariance_core_tb.sv -----
// ---------------------------------------------------------------------------
// chromaticity_running_covariance_core_tb
// Drives masked BGR pixels and clear commands through the core under random
// input and output idling and several mask thresholds. A local Welford model
// predicts every result, and the monitor compares each one as a whole.
// ---------------------------------------------------------------------------
module chromaticity_running_covariance_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chrcov_pkg::*;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;
  localparam longint CHR_MAX   = 64'hFF_FFFF;
  localparam longint VAR_MAX   = 64'hFF_FFFF_FFFF;
  localparam longint COV_MAX   = 64'h7F_FFFF_FFFF;
  localparam longint COV_MIN   = -64'sh80_0000_0000;
  localparam longint CNT_MAX   = (64'd1 << COUNT_W) - 1;
  localparam int     CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic       func;
    logic [7:0] pb, pg, pr, mb, mg, mr;
  } pixel_t;

  typedef struct packed {
    logic                acc;
    logic                full;
    logic [COUNT_W-1:0]  cnt;
    logic [CHR_W-1:0]    mr, mg;
    logic [MOM_W-1:0]    vr, vg, cv;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic func_i = 1'b0;
  logic [7:0] pixel_blue_i = '0, pixel_green_i = '0, pixel_red_i = '0;
  logic [7:0] mask_blue_i = '0, mask_green_i = '0, mask_red_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic accepted_o, count_full_o;
  logic [COUNT_W-1:0] sample_count_o;
  logic [CHR_W-1:0] mean_red_o, mean_green_o;
  logic [MOM_W-1:0] moment_red_o, moment_green_o;
  logic signed [MOM_W-1:0] moment_cross_o;

  always #5 clk_i = ~clk_i;

  chromaticity_running_covariance_core dut (.*);

  // predictor state: threshold plus the running statistics
  logic [7:0] thr_model;
  longint cnt_m, mean_r_m, mean_g_m, var_r_m, var_g_m, cov_m;

  pixel_t pixel_q[$];      // items waiting for the driver
  stats_t stats_q[$];      // predicted results, oldest first
  pixel_t cur_pixel;
  int     in_gap, out_gap;
  bit     quiet;           // no idling in the last stretch
  int     n_items, n_sampled, n_clears, n_results, n_errors;
  int     cycles;

  function automatic longint chroma(longint c, longint s);
    longint q;
    q = (c << 24) / s;
    return (q > CHR_MAX) ? CHR_MAX : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Welford second-moment update, Q0.48 product truncated to Q0.40
  function automatic longint moment_step(longint m, longint dx, longint dy, longint n,
                                         longint lo, longint hi);
    longint t;
    t = dx * dy;
    t = t * (n - 1);
    t = t / 256;
    return clamp(m + t - m / n, lo, hi);
  endfunction

  function automatic stats_t predict_stats(pixel_t p);
    stats_t e;
    longint s, r, g, dr, dg;
    e.acc  = 1'b0;
    e.full = 1'b0;
    if (p.func == FUNC_CLEAR) begin
      cnt_m = 0; mean_r_m = 0; mean_g_m = 0; var_r_m = 0; var_g_m = 0; cov_m = 0;
      n_clears++;
    end else begin
      s = longint'(p.pr) + longint'(p.pg) + longint'(p.pb);
      if (p.mb > thr_model && p.mg > thr_model && p.mr > thr_model && s != 0) begin
        if (cnt_m >= CNT_MAX) begin
          e.full = 1'b1;
        end else begin
          r = chroma(p.pr, s);
          g = chroma(p.pg, s);
          cnt_m++;
          dr = (r - mean_r_m) / cnt_m;
          dg = (g - mean_g_m) / cnt_m;
          mean_r_m = clamp(mean_r_m + dr, 0, CHR_MAX);
          mean_g_m = clamp(mean_g_m + dg, 0, CHR_MAX);
          cov_m   = moment_step(cov_m, dr, dg, cnt_m, COV_MIN, COV_MAX);
          var_r_m = moment_step(var_r_m, dr, dr, cnt_m, 0, VAR_MAX);
          var_g_m = moment_step(var_g_m, dg, dg, cnt_m, 0, VAR_MAX);
          e.acc = 1'b1;
          n_sampled++;
        end
      end
    end
    e.cnt = COUNT_W'(cnt_m);
    e.mr  = CHR_W'(mean_r_m);
    e.mg  = CHR_W'(mean_g_m);
    e.vr  = MOM_W'(var_r_m);
    e.vg  = MOM_W'(var_g_m);
    e.cv  = MOM_W'(cov_m);
    return e;
  endfunction

  // Driver: record the transfer, then hold, idle or present the next pixel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        stats_q.push_back(predict_stats(cur_pixel));
        n_items++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() != 0 && (quiet || $urandom_range(0, 4) != 0)) begin
          cur_pixel = pixel_q.pop_front();
          func_i        <= cur_pixel.func;
          pixel_blue_i  <= cur_pixel.pb;
          pixel_green_i <= cur_pixel.pg;
          pixel_red_i   <= cur_pixel.pr;
          mask_blue_i   <= cur_pixel.mb;
          mask_green_i  <= cur_pixel.mg;
          mask_red_i    <= cur_pixel.mr;
          in_valid_i    <= 1'b1;
        end else begin
          if (pixel_q.size() != 0) in_gap = int'($urandom_range(0, 4));
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random result stalls, compare each transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    stats_t a;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap = 0;
    end else begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results pending", cycles, stats_q.size());
        $display("chromaticity_running_covariance_core_tb: FAIL");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        a = {accepted_o, count_full_o, sample_count_o, mean_red_o, mean_green_o,
             moment_red_o, moment_green_o, moment_cross_o};
        n_results++;
        if (stats_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result transfer: %p", a);
        end else begin
          e = stats_q.pop_front();
          if (a !== e) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("result %0d mismatch", n_results);
              $display("  exp acc=%0b full=%0b cnt=%0d mr=%h mg=%h vr=%h vg=%h cv=%h",
                       e.acc, e.full, e.cnt, e.mr, e.mg, e.vr, e.vg, e.cv);
              $display("  got acc=%0b full=%0b cnt=%0d mr=%h mg=%h vr=%h vg=%h cv=%h",
                       a.acc, a.full, a.cnt, a.mr, a.mg, a.vr, a.vg, a.cv);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = int'($urandom_range(0, 4));
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic pixel_t mk(logic f, logic [7:0] pb, pg, pr, mb, mg, mr);
    mk = {f, pb, pg, pr, mb, mg, mr};
  endfunction

  // mostly pixels that pass the mask, with clears and random masks mixed in
  task automatic queue_random(int cnt);
    pixel_t p;
    int k;
    repeat (cnt) begin
      k = int'($urandom_range(0, 19));
      p = mk(FUNC_SAMPLE, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
      if (k == 0) p.func = FUNC_CLEAR;
      else if (k > 3) begin
        p.mb = 8'($urandom_range(thr_model == 8'hFF ? 255 : thr_model + 1, 255));
        p.mg = 8'($urandom_range(thr_model == 8'hFF ? 255 : thr_model + 1, 255));
        p.mr = 8'($urandom_range(thr_model == 8'hFF ? 255 : thr_model + 1, 255));
        if (k == 4) p.pb = 8'd0;                  // two-channel pixels
        if (k == 5) begin p.pg = 8'd0; p.pb = 8'd0; end
      end
      pixel_q.push_back(p);
    end
  endtask

  // let everything drain so the threshold only changes while idle
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid_i || stats_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    thr_model = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    thr_model = THR_RESET;
    cnt_m = 0; mean_r_m = 0; mean_g_m = 0; var_r_m = 0; var_g_m = 0; cov_m = 0;
    quiet = 1'b0;
    n_items = 0; n_sampled = 0; n_clears = 0; n_results = 0; n_errors = 0; cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset threshold of 100
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd10, 8'd20, 8'd30, 8'd101, 8'd101, 8'd101));
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd10, 8'd20, 8'd30, 8'd100, 8'd255, 8'd255)); // at thr
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd10, 8'd20, 8'd30, 8'd255, 8'd100, 8'd255));
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd10, 8'd20, 8'd30, 8'd255, 8'd255, 8'd0));
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255)); // black
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255)); // pure red
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255)); // green
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255)); // blue
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd0, 8'd0, 8'd1, 8'd200, 8'd200, 8'd200));
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd1, 8'd1, 8'd1, 8'd200, 8'd200, 8'd200));
    pixel_q.push_back(mk(FUNC_CLEAR, 8'd50, 8'd50, 8'd50, 8'd255, 8'd255, 8'd255));
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd0, 8'd1, 8'd0, 8'd255, 8'd255, 8'd255));
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
    pixel_q.push_back(mk(FUNC_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    queue_random(140);
    drain();

    // threshold 0: any nonzero mask passes
    write_threshold(8'd0);
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd9, 8'd9, 8'd9, 8'd1, 8'd1, 8'd1));
    pixel_q.push_back(mk(FUNC_SAMPLE, 8'd9, 8'd9, 8'd9, 8'd0, 8'd1, 8'd1));
    queue_random(140);
    drain();

    // threshold 255: nothing can pass
    write_threshold(8'hFF);
    queue_random(30);
    drain();

    // random threshold, ending with a no-idle stretch
    write_threshold(8'($urandom_range(1, 254)));
    queue_random(220);
    while (pixel_q.size() > 70) @(posedge clk_i);
    quiet = 1'b1;
    drain();
    repeat (20) @(posedge clk_i);

    $display("%0d items (%0d sampled, %0d clears), %0d results, four thresholds",
             n_items, n_sampled, n_clears, n_results);
    if (n_errors == 0 && stats_q.size() == 0) begin
      $display("chromaticity_running_covariance_core_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, stats_q.size());
      $display("chromaticity_running_covariance_core_tb: FAIL");
    end
    $finish;
  end

endmodule
